/* src/adt_pkg.sv */
package adt_pkg;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQI,
		OP_SQJ,
		OP_DEN,
		OP_THR,
		OP_PI,
		OP_PJ,
		OP_COMB,
		OP_PL,
		OP_PH,
		OP_PSUM,
		OP_PRE,
		OP_DIV,
		OP_ADD,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic degen;
		logic cap;
	} dp_status_t;

	localparam int unsigned DIV_STEPS = 41;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_X    = 2'd1;
	localparam logic [1:0] AXIS_Y    = 2'd2;
	localparam logic [1:0] AXIS_Z    = 2'd3;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_MOVE  = 1'b1;

	localparam logic [2:0] REG_THRESHOLD_ADDR = 3'd0;

endpackage

/* src/adt_ray_if.sv */
interface adt_ray_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         axis;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	logic signed [31:0] anchor_x;
	logic signed [31:0] anchor_y;
	logic signed [31:0] anchor_z;

	modport source (
		output valid, kind, axis, origin_x, origin_y, origin_z,
		output dir_x, dir_y, dir_z, anchor_x, anchor_y, anchor_z,
		input  ready
	);
	modport sink (
		input  valid, kind, axis, origin_x, origin_y, origin_z,
		input  dir_x, dir_y, dir_z, anchor_x, anchor_y, anchor_z,
		output ready
	);
endinterface

/* src/adt_res_if.sv */
interface adt_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] displacement;
	logic [1:0]         moved_axis;
	logic               degenerate;

	modport source (output valid, displacement, moved_axis, degenerate, input ready);
	modport sink (input valid, displacement, moved_axis, degenerate, output ready);
endinterface

/* src/axis_drag_translation.sv */
// sequence: load, denominator, threshold check, numerator and the restoring divider, then
// the add and finish steps; a none axis skips from load to finish, a parallel ray skips after the threshold check
// and a capped quotient skips the divider; throughput: one item at a time, next item accepted
// in the same cycle as result valid; the bit-serial restoring divider (one quotient bit per cycle) sets the pace
// reset: arst_n clears the latched anchor and closest point to zero and sets
// the parallel threshold register to 7
module axis_drag_translation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	adt_ray_if.sink     ray,
	adt_res_if.source   res
);
	import adt_pkg::*;

	// parallel threshold register, written in the apb access phase
	logic [15:0] threshold_q;
	logic        reg_hit;

	// the single register decodes on the word address bit only
	assign reg_hit = (paddr[2] == REG_THRESHOLD_ADDR[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 16'd7;
		end else if (psel && penable && pwrite && reg_hit) begin
			threshold_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_hit ? {16'b0, threshold_q} : '0;

	// controller to datapath command and status
	dp_cmd_t    cmd;
	dp_status_t st;

	// sequencer: one item in flight, result held in the output register
	// until its transfer, while the next item may already start
	adt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ray.valid),
		.in_ready  (ray.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.st        (st)
	);

	// datapath: shared 32x33 multiplier, denominator and numerator build-up,
	// restoring divider, saturation and the start-of-drag state
	adt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.threshold    (threshold_q),
		.kind         (ray.kind),
		.axis         (ray.axis),
		.origin_x     (ray.origin_x),
		.origin_y     (ray.origin_y),
		.origin_z     (ray.origin_z),
		.dir_x        (ray.dir_x),
		.dir_y        (ray.dir_y),
		.dir_z        (ray.dir_z),
		.anchor_x     (ray.anchor_x),
		.anchor_y     (ray.anchor_y),
		.anchor_z     (ray.anchor_z),
		.displacement (res.displacement),
		.moved_axis   (res.moved_axis),
		.degenerate   (res.degenerate)
	);

endmodule

/* src/adt_ctrl.sv */
module adt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output adt_pkg::dp_cmd_t    cmd,
	input  adt_pkg::dp_status_t st
);
	import adt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQI,
		S_SQJ,
		S_DEN,
		S_THR,
		S_PI,
		S_PJ,
		S_COMB,
		S_PL,
		S_PH,
		S_PSUM,
		S_PRE,
		S_DIV,
		S_ADD,
		S_FIN
	} state_t;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
	logic                 out_valid_q, out_valid_d;
	logic                 commit;

	assign commit = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.op      = OP_NOP;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SQI;
				end
			end
			S_SQI: begin
				if (st.degen) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_SQI;
					state_d = S_SQJ;
				end
			end
			S_SQJ: begin
				cmd.op  = OP_SQJ;
				state_d = S_DEN;
			end
			S_DEN: begin
				cmd.op  = OP_DEN;
				state_d = S_THR;
			end
			S_THR: begin
				cmd.op  = OP_THR;
				state_d = S_PI;
			end
			S_PI: begin
				if (st.degen) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_PI;
					state_d = S_PJ;
				end
			end
			S_PJ: begin
				cmd.op  = OP_PJ;
				state_d = S_COMB;
			end
			S_COMB: begin
				cmd.op  = OP_COMB;
				state_d = S_PL;
			end
			S_PL: begin
				cmd.op  = OP_PL;
				state_d = S_PH;
			end
			S_PH: begin
				cmd.op  = OP_PH;
				state_d = S_PSUM;
			end
			S_PSUM: begin
				cmd.op  = OP_PSUM;
				state_d = S_PRE;
			end
			S_PRE: begin
				cmd.op  = OP_PRE;
				cnt_d   = DIV_CNT_W'(DIV_STEPS - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.cap) begin
					state_d = S_ADD;
				end else begin
					cmd.op = OP_DIV;
					if (cnt_q == '0) state_d = S_ADD;
					else cnt_d = cnt_q - DIV_CNT_W'(1);
				end
			end
			S_ADD: begin
				cmd.op  = OP_ADD;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (commit) begin
					cmd.op      = OP_FIN;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	// a new result only appears from the finish step
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result valid without finish step");

	// the divider counter stays within the step count
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("divider counter out of range");

endmodule

/* src/adt_datapath.sv */
module adt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  adt_pkg::dp_cmd_t    cmd,
	output adt_pkg::dp_status_t st,
	input  logic [15:0]         threshold,
	input  logic                kind,
	input  logic [1:0]          axis,
	input  logic signed [31:0]  origin_x,
	input  logic signed [31:0]  origin_y,
	input  logic signed [31:0]  origin_z,
	input  logic signed [31:0]  dir_x,
	input  logic signed [31:0]  dir_y,
	input  logic signed [31:0]  dir_z,
	input  logic signed [31:0]  anchor_x,
	input  logic signed [31:0]  anchor_y,
	input  logic signed [31:0]  anchor_z,
	output logic signed [31:0]  displacement,
	output logic [1:0]          moved_axis,
	output logic                degenerate
);
	import adt_pkg::*;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? (~v + 33'd1) : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		if (v > 44'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -44'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

	// architectural state, reset to zero
	logic signed [31:0] sp_q  [3];
	logic signed [31:0] scp_q [3];

	// per-item registers
	logic               kind_q;
	logic [1:0]         axis_q;
	logic               degen_q;
	logic               cap_q;
	logic signed [31:0] anc_q [3];
	logic signed [31:0] org_k_q;
	logic signed [31:0] scp_k_q;
	logic [31:0]        di_q, dj_q, dk_q;
	logic               dk_neg_q, ni_q, nj_q;
	logic [32:0]        wi_q, wj_q;
	logic [63:0]        prod_q, den_q, pi_q, smag_q, plo_q;
	logic               sneg_q;
	logic [95:0]        p_q;
	logic [63:0]        rem_q;
	logic [40:0]        dvd_q, quo_q;
	logic signed [42:0] cp_q;

	// load-time selection of the axis roles
	logic signed [31:0] o_i, o_j, o_k, d_i, d_j, d_k, b_i, b_j, s_k;
	logic signed [31:0] base [3];
	logic signed [32:0] w_i, w_j;

	always_comb begin
		base[0] = (kind == KIND_START) ? anchor_x : sp_q[0];
		base[1] = (kind == KIND_START) ? anchor_y : sp_q[1];
		base[2] = (kind == KIND_START) ? anchor_z : sp_q[2];
		unique case (axis)
			AXIS_X: begin
				o_i = origin_y; o_j = origin_z; o_k = origin_x;
				d_i = dir_y;    d_j = dir_z;    d_k = dir_x;
				b_i = base[1];  b_j = base[2];  s_k = scp_q[0];
			end
			AXIS_Y: begin
				o_i = origin_z; o_j = origin_x; o_k = origin_y;
				d_i = dir_z;    d_j = dir_x;    d_k = dir_y;
				b_i = base[2];  b_j = base[0];  s_k = scp_q[1];
			end
			AXIS_Z: begin
				o_i = origin_x; o_j = origin_y; o_k = origin_z;
				d_i = dir_x;    d_j = dir_y;    d_k = dir_z;
				b_i = base[0];  b_j = base[1];  s_k = scp_q[2];
			end
			default: begin
				o_i = '0; o_j = '0; o_k = '0;
				d_i = '0; d_j = '0; d_k = '0;
				b_i = '0; b_j = '0; s_k = '0;
			end
		endcase
		w_i = 33'(b_i) - 33'(o_i);
		w_j = 33'(b_j) - 33'(o_j);
	end

	// shared multiplier
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [64:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQI:  begin mul_a = di_q; mul_b = {1'b0, di_q}; end
			OP_SQJ:  begin mul_a = dj_q; mul_b = {1'b0, dj_q}; end
			OP_PI:   begin mul_a = di_q; mul_b = wi_q; end
			OP_PJ:   begin mul_a = dj_q; mul_b = wj_q; end
			OP_PL:   begin mul_a = dk_q; mul_b = {1'b0, smag_q[31:0]}; end
			OP_PH:   begin mul_a = dk_q; mul_b = {1'b0, smag_q[63:32]}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = 65'(mul_a) * 65'(mul_b);
	end

	// restoring divider step
	logic [64:0] div_t;
	logic        div_ge;
	logic [64:0] div_r;

	assign div_t  = {rem_q, dvd_q[40]};
	assign div_ge = div_t >= {1'b0, den_q};
	assign div_r  = div_t - {1'b0, den_q};

	// quotient sign, magnitude and final sums
	logic        qneg;
	logic [40:0] qmag;
	logic signed [42:0] qs;
	logic signed [43:0] diff;

	assign qneg = dk_neg_q ^ sneg_q;
	assign qmag = (cap_q || (quo_q[40] && (quo_q[39:0] != '0))) ? {1'b1, 40'b0} : quo_q;
	assign qs   = qneg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
	assign diff = 44'(cp_q) - 44'(scp_k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				sp_q[n]  <= '0;
				scp_q[n] <= '0;
			end
			degen_q <= 1'b0;
			cap_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					kind_q   <= kind;
					axis_q   <= axis;
					degen_q  <= (axis == AXIS_NONE);
					anc_q[0] <= anchor_x;
					anc_q[1] <= anchor_y;
					anc_q[2] <= anchor_z;
					org_k_q  <= o_k;
					scp_k_q  <= s_k;
					di_q     <= mag32(d_i);
					dj_q     <= mag32(d_j);
					dk_q     <= mag32(d_k);
					dk_neg_q <= d_k[31];
					wi_q     <= mag33(w_i);
					wj_q     <= mag33(w_j);
					ni_q     <= d_i[31] ^ w_i[32];
					nj_q     <= d_j[31] ^ w_j[32];
				end
				OP_SQI: prod_q <= mul_p[63:0];
				OP_SQJ: begin
					den_q  <= prod_q;
					prod_q <= mul_p[63:0];
				end
				OP_DEN: den_q <= den_q + prod_q;
				OP_THR: begin
					if (den_q == '0 || den_q < {32'b0, threshold, 16'b0}) degen_q <= 1'b1;
				end
				OP_PI: prod_q <= mul_p[63:0];
				OP_PJ: begin
					pi_q   <= prod_q;
					prod_q <= mul_p[63:0];
				end
				OP_COMB: begin
					// signed sum of the two partial products
					if (ni_q == nj_q) begin
						smag_q <= pi_q + prod_q;
						sneg_q <= ni_q;
					end else if (pi_q >= prod_q) begin
						smag_q <= pi_q - prod_q;
						sneg_q <= ni_q;
					end else begin
						smag_q <= prod_q - pi_q;
						sneg_q <= nj_q;
					end
				end
				OP_PL: prod_q <= mul_p[63:0];
				OP_PH: begin
					plo_q  <= prod_q;
					prod_q <= mul_p[63:0];
				end
				OP_PSUM: p_q <= {32'b0, plo_q} + {prod_q, 32'b0};
				OP_PRE: begin
					// quotient of 2^41 or more saturates without dividing
					cap_q <= {9'b0, p_q[95:41]} >= den_q;
					rem_q <= {9'b0, p_q[95:41]};
					dvd_q <= p_q[40:0];
					quo_q <= '0;
				end
				OP_DIV: begin
					rem_q <= div_ge ? div_r[63:0] : div_t[63:0];
					quo_q <= {quo_q[39:0], div_ge};
					dvd_q <= {dvd_q[39:0], 1'b0};
				end
				OP_ADD: cp_q <= 43'(org_k_q) + qs;
				OP_FIN: begin
					moved_axis <= axis_q;
					degenerate <= degen_q;
					if (kind_q == KIND_START || degen_q) displacement <= '0;
					else displacement <= sat32(diff);
					if (kind_q == KIND_START) begin
						for (int n = 0; n < 3; n++) begin
							sp_q[n]  <= anc_q[n];
							scp_q[n] <= anc_q[n];
						end
						if (!degen_q) begin
							unique case (axis_q)
								AXIS_X:  scp_q[0] <= sat32(44'(cp_q));
								AXIS_Y:  scp_q[1] <= sat32(44'(cp_q));
								AXIS_Z:  scp_q[2] <= sat32(44'(cp_q));
								default: ;
							endcase
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign st.degen = degen_q;
	assign st.cap   = cap_q;

endmodule

/* tb/adt_checker.sv */
`timescale 1ns / 100ps

module adt_checker
	import adt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	adt_ray_if          ray,
	adt_res_if          res,
	output int          fail_count,
	output int          waiting
);

	typedef struct {
		logic signed [31:0] disp;
		logic [1:0]         axis;
		logic               degen;
	} drag_result_t;

	drag_result_t       expected_q[$];
	logic [15:0]        threshold;
	logic signed [31:0] anchor_latch[3];
	logic signed [31:0] closest_latch[3];

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// closest point component k on the axis line through base; 1 when degenerate
	function automatic bit axis_closest(input int k, input logic signed [31:0] o[3],
			input logic signed [31:0] d[3], input logic signed [31:0] b[3],
			output longint cp);
		int                  i;
		int                  j;
		longint              sdi;
		longint              sdj;
		logic [63:0]         den;
		logic signed [127:0] di, dj, wi, wj, s;
		logic [127:0]        smag, dk, q;
		bit                  neg;
		i = (k + 1) % 3;
		j = (k + 2) % 3;
		sdi = d[i];
		sdj = d[j];
		den = 64'(sdi * sdi) + 64'(sdj * sdj);
		cp = 0;
		if (den == 0 || den < {32'd0, threshold, 16'd0})
			return 1;
		di = d[i];
		dj = d[j];
		wi = b[i];
		wi = wi - o[i];
		wj = b[j];
		wj = wj - o[j];
		s = di * wi + dj * wj;
		smag = s < 0 ? -s : s;
		dk = d[k] < 0 ? -128'(longint'(d[k])) : 128'(longint'(d[k]));
		q = (dk * smag) / {64'd0, den};
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		neg = (d[k] < 0) != (s < 0);
		cp = longint'(o[k]) + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
		return 0;
	endfunction

	assign waiting = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] o[3], d[3], a[3];
		drag_result_t        e;
		drag_result_t        got;
		longint              cp;
		int                  k;
		if (!arst_n) begin
			threshold <= 16'd7;
			for (int n = 0; n < 3; n++) begin
				anchor_latch[n] = '0;
				closest_latch[n] = '0;
			end
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD_ADDR)
				threshold <= pwdata[15:0];
			if (ray.valid && ray.ready) begin
				o = '{ray.origin_x, ray.origin_y, ray.origin_z};
				d = '{ray.dir_x, ray.dir_y, ray.dir_z};
				a = '{ray.anchor_x, ray.anchor_y, ray.anchor_z};
				e.disp = '0;
				e.axis = ray.axis;
				e.degen = 1'b1;
				k = int'(ray.axis) - 1;
				if (ray.kind == KIND_START) begin
					anchor_latch = a;
					closest_latch = a;
					if (ray.axis != AXIS_NONE) begin
						e.degen = axis_closest(k, o, d, a, cp);
						if (!e.degen)
							closest_latch[k] = clamp32(cp);
					end
				end else if (ray.axis != AXIS_NONE) begin
					e.degen = axis_closest(k, o, d, anchor_latch, cp);
					if (!e.degen)
						e.disp = clamp32(cp - longint'(closest_latch[k]));
				end
				expected_q.push_back(e);
			end
			if (res.valid && res.ready) begin
				got.disp = res.displacement;
				got.axis = res.moved_axis;
				got.degen = res.degenerate;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer: disp %0d axis %0d degen %0b",
							got.disp, got.axis, got.degen);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (got.disp !== e.disp || got.axis !== e.axis
							|| got.degen !== e.degen) begin
						if (fail_count < 10)
							$display({"result mismatch: exp disp %0d axis %0d degen %0b,",
								" got disp %0d axis %0d degen %0b"},
								e.disp, e.axis, e.degen, got.disp, got.axis, got.degen);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import adt_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int DRAIN = 60;	// wait after the last result, longer than the block's latency

	typedef struct {
		logic               kind;
		logic [1:0]         axis;
		logic signed [31:0] o[3];
		logic signed [31:0] d[3];
		logic signed [31:0] a[3];
	} ray_item_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          waiting;
	int          sent_count;
	int          cycles = 0;
	int          burst_left;

	adt_ray_if ray ();
	adt_res_if res ();

	axis_drag_translation uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.ray(ray), .res(res)
	);

	adt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.ray(ray), .res(res),
		.fail_count(fail_count), .waiting(waiting)
	);

	always #1 clk = ~clk;

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("axis_drag_translation verification failed");
			$finish;
		end
	end

	// receiver: random stall pattern picked from four modes, plus one long hold
	initial begin
		int  mode;
		int  hold;
		bit  held;
		mode = 0;
		hold = 0;
		held = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cycles % 200 == 0)
				mode = $urandom_range(0, 3);
			if (!held && sent_count >= 250) begin
				// long hold-off so the block backs up and stalls its input
				hold = 400;
				held = 1;
			end
			if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else begin
				case (mode)
					0: res.ready <= 1'b1;
					1: res.ready <= $urandom_range(0, 1);
					2: res.ready <= ($urandom_range(0, 3) == 0);
					default: res.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			1: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
		endcase
	endfunction

	function automatic ray_item_t make_ray(input logic kind, input logic [1:0] axis,
			input logic signed [31:0] ox, oy, oz, dx, dy, dz, ax, ay, az);
		ray_item_t r;
		r.kind = kind;
		r.axis = axis;
		r.o = '{ox, oy, oz};
		r.d = '{dx, dy, dz};
		r.a = '{ax, ay, az};
		return r;
	endfunction

	function automatic ray_item_t random_ray(input logic kind, input logic [1:0] axis);
		ray_item_t r;
		r.kind = kind;
		r.axis = axis;
		for (int n = 0; n < 3; n++) begin
			r.o[n] = pick_value();
			r.d[n] = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_value();
			r.a[n] = pick_value();
		end
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_ray(input ray_item_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				ray.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		ray.kind <= r.kind;
		ray.axis <= r.axis;
		ray.origin_x <= r.o[0];
		ray.origin_y <= r.o[1];
		ray.origin_z <= r.o[2];
		ray.dir_x <= r.d[0];
		ray.dir_y <= r.d[1];
		ray.dir_z <= r.d[2];
		ray.anchor_x <= r.a[0];
		ray.anchor_y <= r.a[1];
		ray.anchor_z <= r.a[2];
		ray.valid <= 1'b1;
		@(posedge clk);
		while (!ray.ready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// let every result drain, then give the block its latency
	task automatic wait_idle();
		ray.valid <= 1'b0;
		burst_left = 0;
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_THRESHOLD_ADDR;
		pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [15:0] phase_thr[4];
		ray_item_t   r;
		logic [1:0]  ax;
		int          moves;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_count = 0;
		burst_left = 0;
		ray.valid = 1'b0;
		ray.kind = KIND_START;
		ray.axis = AXIS_NONE;
		ray.origin_x = '0;
		ray.origin_y = '0;
		ray.origin_z = '0;
		ray.dir_x = '0;
		ray.dir_y = '0;
		ray.dir_z = '0;
		ray.anchor_x = '0;
		ray.anchor_y = '0;
		ray.anchor_z = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: move before any start runs against the zero reset state
		send_ray(make_ray(KIND_MOVE, AXIS_X, 32'sh10000, 32'sh20000, 0,
			32'sh10000, 32'sh10000, 32'sh10000, 5, 5, 5));
		// plain start and move on each axis
		send_ray(make_ray(KIND_START, AXIS_X, 0, 32'sh50000, 0,
			32'sh10000, -32'sh10000, 0, 32'sh30000, 0, 0));
		send_ray(make_ray(KIND_MOVE, AXIS_X, 32'sh20000, 32'sh50000, 0,
			32'sh10000, -32'sh10000, 0, 1, 2, 3));
		send_ray(make_ray(KIND_START, AXIS_Y, 32'sh40000, 0, 32'sh40000,
			-32'sh10000, 32'sh8000, -32'sh10000, 0, 32'sh10000, 0));
		send_ray(make_ray(KIND_MOVE, AXIS_Y, 32'sh30000, 32'sh10000, 32'sh40000,
			-32'sh10000, 32'sh8000, -32'sh8000, 0, 0, 0));
		send_ray(make_ray(KIND_START, AXIS_Z, 0, 0, 0,
			32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000));
		send_ray(make_ray(KIND_MOVE, AXIS_Z, -32'sh10000, 32'sh10000, 0,
			32'sh10000, -32'sh20000, 32'sh30000, 0, 0, 0));
		// axis none, start and move
		send_ray(make_ray(KIND_START, AXIS_NONE, 1, 2, 3, 4, 5, 6, 7, 8, 9));
		send_ray(make_ray(KIND_MOVE, AXIS_NONE, 1, 2, 3, 4, 5, 6, 7, 8, 9));
		// ray parallel to the axis: both other components zero
		send_ray(make_ray(KIND_START, AXIS_X, 0, 0, 0,
			32'sh10000, 0, 0, 32'sh10000, 0, 0));
		send_ray(make_ray(KIND_MOVE, AXIS_X, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0));
		// near parallel, both below the threshold of 7
		send_ray(make_ray(KIND_MOVE, AXIS_Y, 0, 0, 0, 2, 32'sh10000, 1, 0, 0, 0));
		send_ray(make_ray(KIND_MOVE, AXIS_Y, 0, 0, 0, 32'sh200, 32'sh10000, 32'sh180, 0, 0, 0));
		// field extremes: quotient cap and saturation
		send_ray(make_ray(KIND_START, AXIS_Z, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			1, -1, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		send_ray(make_ray(KIND_MOVE, AXIS_Z, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
		send_ray(make_ray(KIND_MOVE, AXIS_X, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0));
		send_ray(make_ray(KIND_START, AXIS_Y, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_ray(make_ray(KIND_MOVE, AXIS_Y, 32'sh7fffffff, 0, 32'sh80000000,
			32'sh40000000, 32'sh7fffffff, -32'sh40000000, 0, 0, 0));
		// zero direction along the axis
		send_ray(make_ray(KIND_MOVE, AXIS_Y, 5, 6, 7, 32'sh10000, 0, 32'sh10000, 0, 0, 0));

		// random phases: threshold zero, maximum, random, back to reset value
		phase_thr = '{16'd0, 16'hffff, 16'($urandom), 16'd7};
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_threshold(phase_thr[p]);
			while (sent_count < 20 + (p + 1) * 170) begin
				if ($urandom_range(0, 99) < 85) begin
					// drag gesture: a start then a run of moves on the same axis
					ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(1, 3));
					send_ray(random_ray(KIND_START, ax));
					moves = $urandom_range(1, 6);
					for (int m = 0; m < moves; m++) begin
						r = random_ray(KIND_MOVE, ax);
						send_ray(r);
					end
				end else begin
					send_ray(random_ray(1'($urandom), 2'($urandom)));
				end
			end
		end

		wait_idle();
		if (fail_count == 0 && waiting == 0) begin
			$display("axis_drag_translation verification clean");
		end else begin
			$display("axis_drag_translation verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
src/adt_pkg.sv
src/adt_ray_if.sv
src/adt_res_if.sv
src/adt_ctrl.sv
src/adt_datapath.sv
src/axis_drag_translation.sv
tb/adt_checker.sv
tb/tb_top.sv
